### sv/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg
// shared constants, status codes and the back end state type of the
// streaming sample variance block
// ----------------------------------------------------------------------------
package ssv_pkg;

   // default configuration
   localparam int MAX_SAMPLES_DEFAULT = 65536;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // depth of the queue of finished data sets between front and back
   localparam int JOB_QUEUE_DEPTH = 2;

   // result field widths
   localparam int VARIANCE_W = 31;
   localparam int COUNT_W    = 17;
   localparam int STATUS_W   = 2;

   localparam logic [VARIANCE_W-1:0] VARIANCE_MAX = 31'h7FFF_FFFF;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_N,
      BK_MUL_S,
      BK_DIVIDE,
      BK_DONE
   } back_state_type;

endpackage

### sv/ssv_job_queue.sv
// ----------------------------------------------------------------------------
// ssv_job_queue
// small register queue that holds finished data sets until the back end
// takes them
// ----------------------------------------------------------------------------
module ssv_job_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count beyond depth");

endmodule

### sv/ssv_front.sv
// ----------------------------------------------------------------------------
// ssv_front
// accumulates sum, sum of squares and count, one sample per cycle while the
// job queue is not full, and hands each finished data set to the job queue
// ----------------------------------------------------------------------------
module ssv_front #(
   parameter int MAX_SAMPLES = ssv_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = ssv_pkg::SAMPLE_BITS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_W = SAMPLE_BITS + CNT_W,
   localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W,
   localparam int JOB_W = SUM_W + SQ_W + CNT_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   input  logic                   job_full,
   output logic                   job_push,
   output logic [JOB_W-1:0]       job_data
);

   logic signed [SAMPLE_BITS-1:0]   value;
   logic [SAMPLE_BITS-1:0]          mag;
   logic [2*SAMPLE_BITS-1:0]        square;
   logic signed [SUM_W-1:0]         sum_ff, sum_in, sum_next;
   logic [SQ_W-1:0]                 sq_ff, sq_in, sq_next;
   logic [CNT_W-1:0]                seen_ff, seen_in, seen_next;
   logic                            lim_ff, lim_in, lim_next;
   logic                            accept, at_limit;

   assign value    = $signed(req_sample);
   assign mag      = value[SAMPLE_BITS-1] ? SAMPLE_BITS'(-value) : req_sample;
   assign square   = mag * mag;
   assign accept   = req_push && !job_full;
   assign at_limit = (seen_ff >= CNT_W'(MAX_SAMPLES));

   // a sample past the count limit is dropped and only flagged
   assign sum_next  = at_limit ? sum_ff  : sum_ff + SUM_W'(value);
   assign sq_next   = at_limit ? sq_ff   : sq_ff + SQ_W'(square);
   assign seen_next = at_limit ? seen_ff : seen_ff + 1'b1;
   assign lim_next  = lim_ff | at_limit;

   assign job_push = accept && req_last;
   assign job_data = {sum_next, sq_next, seen_next, lim_next};

   always_comb begin
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      seen_in = seen_ff;
      lim_in  = lim_ff;
      if (accept) begin
         if (req_last) begin
            sum_in  = '0;
            sq_in   = '0;
            seen_in = '0;
            lim_in  = 1'b0;
         end else begin
            sum_in  = sum_next;
            sq_in   = sq_next;
            seen_in = seen_next;
            lim_in  = lim_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         sq_ff   <= '0;
         seen_ff <= '0;
         lim_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         seen_ff <= seen_in;
         lim_ff  <= lim_in;
      end
   end

   a_limit_flag_only_at_max: assert property (@(posedge clock) disable iff (reset)
      lim_ff |-> (seen_ff == CNT_W'(MAX_SAMPLES)))
      else $error("limit flag set below the sample limit");

endmodule

### sv/ssv_back.sv
// ----------------------------------------------------------------------------
// ssv_back
// per data set: shift-add products n*S2 and S*S, restoring division by
// n*(n-1), saturation and the result register
// ----------------------------------------------------------------------------
module ssv_back #(
   parameter int MAX_SAMPLES = ssv_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = ssv_pkg::SAMPLE_BITS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_W = SAMPLE_BITS + CNT_W,
   localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W,
   localparam int JOB_W = SUM_W + SQ_W + CNT_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_empty,
   input  logic [JOB_W-1:0]                job_data,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [ssv_pkg::VARIANCE_W-1:0]  rsp_variance,
   output logic [ssv_pkg::COUNT_W-1:0]     rsp_sample_count,
   output logic [ssv_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int PROD_W  = 2 * SUM_W;
   localparam int DIV_W   = 2 * CNT_W;
   localparam int STEP_W  = $clog2(PROD_W + 1);
   localparam int VAR_EXT = (PROD_W > 32) ? PROD_W : 32;
   localparam int CNT_EXT = (CNT_W > ssv_pkg::COUNT_W) ? CNT_W : ssv_pkg::COUNT_W;

   ssv_pkg::back_state_type state_ff, state_in;

   logic signed [SUM_W-1:0]  job_sum;
   logic [SQ_W-1:0]          job_sq;
   logic [CNT_W-1:0]         job_n;
   logic                     job_lim;
   logic [SUM_W-1:0]         job_sum_mag;

   logic [PROD_W-1:0]        mcand_ff, mcand_in;
   logic [SUM_W-1:0]         mplier_ff, mplier_in;
   logic [SUM_W-1:0]         sum_mag_ff, sum_mag_in;
   logic signed [PROD_W:0]   diff_ff, diff_in, diff_step;
   logic [DIV_W-1:0]         d_ff, d_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W:0]           rem_shift;
   logic                     quot_bit;
   logic [PROD_W-1:0]        quot_ff, quot_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic                     lim_ff, lim_in;
   logic                     short_ff, short_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ssv_pkg::VARIANCE_W-1:0]     rsp_variance_ff, rsp_variance_in;
   logic [ssv_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [ssv_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic [VAR_EXT-1:0]       quot_ext;
   logic [CNT_EXT-1:0]       count_ext;
   logic                     rsp_free;

   assign {job_sum, job_sq, job_n, job_lim} = job_data;
   assign job_sum_mag = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : job_sum;

   assign quot_ext  = VAR_EXT'(quot_ff);
   assign count_ext = CNT_EXT'(n_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_pop;

   assign rem_shift = {rem_ff, quot_ff[PROD_W-1]};
   assign quot_bit  = (rem_shift >= {1'b0, d_ff});

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_variance     = rsp_variance_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in        = state_ff;
      mcand_in        = mcand_ff;
      mplier_in       = mplier_ff;
      sum_mag_in      = sum_mag_ff;
      diff_in         = diff_ff;
      diff_step       = diff_ff;
      d_in            = d_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      step_in         = step_ff;
      n_in            = n_ff;
      lim_in          = lim_ff;
      short_in        = short_ff;
      job_pop         = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      rsp_variance_in = rsp_variance_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;

      case (state_ff)
         ssv_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               n_in       = job_n;
               lim_in     = job_lim;
               short_in   = (job_n < CNT_W'(2));
               sum_mag_in = job_sum_mag;
               mcand_in   = PROD_W'(job_sq);
               mplier_in  = SUM_W'(job_n);
               diff_in    = '0;
               d_in       = DIV_W'(job_n) * DIV_W'(job_n - 1'b1);
               step_in    = '0;
               state_in   = (job_n < CNT_W'(2)) ? ssv_pkg::BK_DONE : ssv_pkg::BK_MUL_N;
            end
         end
         ssv_pkg::BK_MUL_N: begin
            // n * S2, one bit of n a cycle
            if (mplier_ff[0]) begin
               diff_step = diff_ff + $signed({1'b0, mcand_ff});
            end
            diff_in   = diff_step;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               mcand_in  = PROD_W'(sum_mag_ff);
               mplier_in = sum_mag_ff;
               step_in   = '0;
               state_in  = ssv_pkg::BK_MUL_S;
            end
         end
         ssv_pkg::BK_MUL_S: begin
            // minus S * S, one bit of |S| a cycle
            if (mplier_ff[0]) begin
               diff_step = diff_ff - $signed({1'b0, mcand_ff});
            end
            diff_in   = diff_step;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               // a negative difference gives a variance of zero
               quot_in  = diff_step[PROD_W] ? '0 : diff_step[PROD_W-1:0];
               rem_in   = '0;
               step_in  = '0;
               state_in = ssv_pkg::BK_DIVIDE;
            end
         end
         ssv_pkg::BK_DIVIDE: begin
            // restoring division, dividend shifts out of quot as quotient shifts in
            if (quot_bit) begin
               rem_in = DIV_W'(rem_shift - {1'b0, d_ff});
            end else begin
               rem_in = rem_shift[DIV_W-1:0];
            end
            quot_in = {quot_ff[PROD_W-2:0], quot_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               state_in = ssv_pkg::BK_DONE;
            end
         end
         ssv_pkg::BK_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ext[ssv_pkg::COUNT_W-1:0];
               if (short_ff) begin
                  rsp_variance_in = '0;
                  rsp_status_in   = ssv_pkg::STATUS_SHORT;
               end else begin
                  rsp_variance_in = (|quot_ext[VAR_EXT-1:ssv_pkg::VARIANCE_W])
                                    ? ssv_pkg::VARIANCE_MAX
                                    : quot_ext[ssv_pkg::VARIANCE_W-1:0];
                  rsp_status_in   = lim_ff ? ssv_pkg::STATUS_LIMIT : ssv_pkg::STATUS_OK;
               end
               state_in = ssv_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ssv_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssv_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff        <= mcand_in;
      mplier_ff       <= mplier_in;
      sum_mag_ff      <= sum_mag_in;
      diff_ff         <= diff_in;
      d_ff            <= d_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      step_ff         <= step_in;
      n_ff            <= n_in;
      lim_ff          <= lim_in;
      short_ff        <= short_in;
      rsp_variance_ff <= rsp_variance_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssv_pkg::BK_DIVIDE && step_ff != '0) |-> (rem_ff < d_ff))
      else $error("division remainder not below divisor");

   a_short_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ssv_pkg::STATUS_SHORT) |-> (rsp_variance_ff == '0))
      else $error("short data set with nonzero variance");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssv_pkg::BK_DONE && rsp_free) |=>
         (state_ff == ssv_pkg::BK_IDLE && rsp_valid_ff))
      else $error("finished data set not moved into result register");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ssv_pkg::BK_IDLE && !job_empty))
      else $error("job taken outside idle");

endmodule

### sv/streaming_sample_variance.sv
// ----------------------------------------------------------------------------
// streaming_sample_variance
// one-pass unbiased sample variance over a stream of signed samples
// ----------------------------------------------------------------------------
// Input channel: req_sample with req_last, a transaction at a clock edge with
// req_push high and req_full low. Samples are taken one per cycle while req_full
// is low; the set ends with the sample that carries req_last. Non-last samples
// produce no result.
// Result channel: rsp_variance, rsp_sample_count and rsp_status are valid
// while rsp_empty is low and are taken by rsp_pop.
// A finished set goes into a two-entry job queue. The back end takes it through
// the shift-add products n*S2 and S*S and the bit-per-cycle divider into the
// result register; a set of fewer than two samples goes straight to the result
// register.
// req_full rises while both queue entries hold finished sets, that is when
// sets end faster than the back end finishes them or the receiver leaves a
// result unpopped; samples wait then.
// Synchronous reset clears the accumulators, the queue, the back end state and the result valid flag.
// ----------------------------------------------------------------------------
module streaming_sample_variance #(
   parameter int MAX_SAMPLES = ssv_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = ssv_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   input  logic                            req_last,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [ssv_pkg::VARIANCE_W-1:0]  rsp_variance,
   output logic [ssv_pkg::COUNT_W-1:0]     rsp_sample_count,
   output logic [ssv_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
   localparam int JOB_W = SUM_W + SQ_W + CNT_W + 1;

   logic             job_push, job_full, job_pop, job_empty;
   logic [JOB_W-1:0] job_push_data, job_pop_data;

   assign req_full = job_full;

   ssv_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_last   (req_last),
      .job_full   (job_full),
      .job_push   (job_push),
      .job_data   (job_push_data)
   );

   ssv_job_queue #(
      .WIDTH (JOB_W),
      .DEPTH (ssv_pkg::JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_pop_data),
      .empty     (job_empty)
   );

   ssv_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (job_empty),
      .job_data         (job_pop_data),
      .job_pop          (job_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_variance     (rsp_variance),
      .rsp_sample_count (rsp_sample_count),
      .rsp_status       (rsp_status)
   );

endmodule
